// ----- design/cdq_pkg.sv -----
// Shared types, sizes and ring index helpers for the circular deque core.
package cdq_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_IW  = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int CNT_W   = 11;
    localparam int TDATA_W = 48;
    localparam int MUSER_W = 3;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } op_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        if (i == '0) begin
            return IDX_W'(DEPTH - 1);
        end
        return i - IDX_W'(1);
    endfunction

endpackage

// ----- design/cdq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/circular_deque_core.sv -----
// Double-ended queue over a ring RAM with head, tail and entry count.
// Push beats and beats that find the deque empty (or carry an unused opcode)
// load the output register directly; pop and peek beats first pass through the
// registered read of the entry RAM (state S_READ), then load the output register.
// Throughput: one push beat per cycle while the output slot is free; no beat is accepted during S_READ.
// Synchronous active-low reset clears indices, count and output valid;
// RAM contents are undefined until written and get no clearing pass.
module circular_deque_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [31:0] value_in
    input  logic [cdq_pkg::DATA_W-1:0]  s_tdata,
    // [2:0] opcode
    input  logic [cdq_pkg::OP_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [31:0] value_out, [42:32] count, [47:43] zero
    output logic [cdq_pkg::TDATA_W-1:0] m_tdata,
    // [0] was_empty, [1] overflow, [2] now_empty
    output logic [cdq_pkg::MUSER_W-1:0] m_tuser
);
    import cdq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_IW-1:0]  cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic               out_was_empty_reg, out_was_empty_next;
    logic               out_overflow_reg, out_overflow_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic               out_now_empty_reg, out_now_empty_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic               load_out;
    op_t                op;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [DATA_W-1:0]  rd_data;

    // Ready only in S_IDLE and when the output slot is free at the next edge: empty or being taken now.
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign full     = (cnt_reg == CNT_IW'(DEPTH));
    assign empty    = (cnt_reg == '0);

    always_comb begin
        state_next         = state_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        cnt_next           = cnt_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_value_next     = out_value_reg;
        out_was_empty_next = out_was_empty_reg;
        out_overflow_next  = out_overflow_reg;
        out_count_next     = out_count_reg;
        out_now_empty_next = out_now_empty_reg;
        load_out           = 1'b0;
        wr_en              = 1'b0;
        wr_addr            = tail_reg;
        rd_en              = 1'b0;
        rd_addr            = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_value_next     = '0;
                    out_was_empty_next = 1'b0;
                    out_overflow_next  = 1'b0;
                    load_out           = 1'b1;
                    unique case (op)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                out_overflow_next = 1'b1;
                            end else begin
                                head_next = ring_prev(head_reg);
                                wr_en     = 1'b1;
                                wr_addr   = ring_prev(head_reg);
                                cnt_next  = cnt_reg + CNT_IW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                out_overflow_next = 1'b1;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = tail_reg;
                                tail_next = ring_next(tail_reg);
                                cnt_next  = cnt_reg + CNT_IW'(1);
                            end
                        end
                        OP_POP_FRONT, OP_PEEK_FRONT: begin
                            if (empty) begin
                                out_value_next     = EMPTY_VALUE;
                                out_was_empty_next = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                load_out   = 1'b0;
                                state_next = S_READ;
                                if (op == OP_POP_FRONT) begin
                                    head_next = ring_next(head_reg);
                                    cnt_next  = cnt_reg - CNT_IW'(1);
                                end
                            end
                        end
                        OP_POP_BACK, OP_PEEK_BACK: begin
                            if (empty) begin
                                out_value_next     = EMPTY_VALUE;
                                out_was_empty_next = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = ring_prev(tail_reg);
                                load_out   = 1'b0;
                                state_next = S_READ;
                                if (op == OP_POP_BACK) begin
                                    tail_next = ring_prev(tail_reg);
                                    cnt_next  = cnt_reg - CNT_IW'(1);
                                end
                            end
                        end
                        default: begin
                            // unused opcodes: report state, change nothing
                        end
                    endcase
                end
            end
            S_READ: begin
                // output slot is empty here: nothing was loaded on the accept edge
                out_value_next     = rd_data;
                out_was_empty_next = 1'b0;
                out_overflow_next  = 1'b0;
                load_out           = 1'b1;
                state_next         = S_IDLE;
            end
        endcase

        if (load_out) begin
            out_valid_next     = 1'b1;
            out_count_next     = CNT_W'(cnt_next);
            out_now_empty_next = (cnt_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        out_value_reg     <= out_value_next;
        out_was_empty_reg <= out_was_empty_next;
        out_overflow_reg  <= out_overflow_next;
        out_count_reg     <= out_count_next;
        out_now_empty_reg <= out_now_empty_next;
    end

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - CNT_W - DATA_W)'(0), out_count_reg, out_value_reg};
    assign m_tuser  = {out_now_empty_reg, out_overflow_reg, out_was_empty_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_IW'(DEPTH))
        else $error("entry count above depth");

    a_ring_meets: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == CNT_IW'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("head and tail disagree with empty or full count");

    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("output slot busy during RAM read cycle");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
        |=> (cnt_reg == $past(cnt_reg) + CNT_IW'(1)))
        else $error("accepted push did not advance the count");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("read cycle did not deliver a result");
`endif

endmodule
